[sv/replay_pair_counter_table_macros.svh]
// Assertion shorthands shared by the checkers of the pair counter table.
`ifndef REPLAY_PAIR_COUNTER_TABLE_MACROS_SVH
`define REPLAY_PAIR_COUNTER_TABLE_MACROS_SVH

// Implication checked on every rising clk edge outside reset.
`define RPCT_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Condition that must never be seen outside reset.
`define RPCT_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

[sv/rpct_pkg.sv]
package rpct_pkg;

	localparam int TABLE_DEPTH_DEF = 64;
	localparam int COUNT_BITS_DEF  = 16;

	localparam int MAC_W     = 48;
	localparam int FLEN_W    = 12;
	localparam int RLEN_W    = 8;
	localparam int MAXPL_W   = 12;
	localparam int THR_W     = 16;
	localparam int HDR_W     = 8;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_W     = 16;
	localparam int IDX_OUT_W = 6;
	localparam int CNT_OUT_W = 16;
	localparam int PL_W      = 14;

	localparam logic [CFG_IDX_W-1:0] REG_MAX_PAYLOAD = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ALARM_THR   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_HEADER      = 2'd2;

	localparam logic [MAXPL_W-1:0] MAX_PAYLOAD_RST = 12'd100;
	localparam logic [THR_W-1:0]   ALARM_THR_RST   = 16'd10;
	localparam logic [HDR_W-1:0]   HEADER_RST      = 8'd27;

	typedef enum logic [1:0] {
		ACT_IGNORED  = 2'd0,
		ACT_HIT      = 2'd1,
		ACT_INSERTED = 2'd2,
		ACT_DROPPED  = 2'd3
	} action_t;

	typedef struct packed {
		logic hit;
		logic alarm;
	} match_t;

	// Payload length must land in 1..max_payload.
	function automatic logic payload_ok(input logic [FLEN_W-1:0] flen,
			input logic [RLEN_W-1:0] rlen, input logic [HDR_W-1:0] hdr,
			input logic [MAXPL_W-1:0] max_pl);
		logic [PL_W-1:0] pl;
		pl = {2'b00, flen} - {6'b0, rlen} - {6'b0, hdr};
		return !pl[PL_W-1] && (pl != '0) && (pl[PL_W-2:0] <= {1'b0, max_pl});
	endfunction

endpackage

[sv/rpct_table.sv]
module rpct_table
	import rpct_pkg::*;
#(
	parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
	parameter int COUNT_BITS  = COUNT_BITS_DEF,
	parameter int IDX_W       = $clog2(TABLE_DEPTH)
) (
	input  logic                  clk,
	input  logic                  rd_en,
	input  logic [IDX_W-1:0]      rd_addr,
	output logic [MAC_W-1:0]      rd_src,
	output logic [MAC_W-1:0]      rd_dst,
	output logic [COUNT_BITS-1:0] rd_cnt,
	input  logic                  wr_en,
	input  logic [IDX_W-1:0]      wr_addr,
	input  logic [MAC_W-1:0]      wr_src,
	input  logic [MAC_W-1:0]      wr_dst,
	input  logic [COUNT_BITS-1:0] wr_cnt
);

	localparam int WORD_W = 2 * MAC_W + COUNT_BITS;

	logic [WORD_W-1:0] mem [TABLE_DEPTH];
	logic [WORD_W-1:0] rd_word_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= {wr_src, wr_dst, wr_cnt};
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_word_q <= mem[rd_addr];
		end
	end

	assign rd_src = rd_word_q[WORD_W-1 -: MAC_W];
	assign rd_dst = rd_word_q[COUNT_BITS +: MAC_W];
	assign rd_cnt = rd_word_q[COUNT_BITS-1:0];

endmodule

[sv/rpct_match.sv]
module rpct_match
	import rpct_pkg::*;
#(
	parameter int COUNT_BITS = COUNT_BITS_DEF
) (
	input  logic [MAC_W-1:0]      ent_src,
	input  logic [MAC_W-1:0]      ent_dst,
	input  logic [COUNT_BITS-1:0] ent_cnt,
	input  logic [MAC_W-1:0]      key_src,
	input  logic [MAC_W-1:0]      key_dst,
	input  logic [THR_W-1:0]      threshold,
	output match_t                res,
	output logic [COUNT_BITS-1:0] next_cnt
);

	localparam int CMP_W = (COUNT_BITS > THR_W) ? COUNT_BITS : THR_W;

	logic [CMP_W-1:0] cnt_ext;
	logic [CMP_W-1:0] thr_ext;

	// Saturate at all ones.
	assign next_cnt = (ent_cnt == '1) ? ent_cnt : ent_cnt + 1'b1;

	assign cnt_ext = CMP_W'(next_cnt);
	assign thr_ext = CMP_W'(threshold);

	assign res.hit   = (ent_src == key_src) && (ent_dst == key_dst);
	assign res.alarm = cnt_ext >= thr_ext;

endmodule

[sv/replay_pair_counter_table.sv]
// Counter table of (source, destination) address pairs. Pulse start while busy is low to
// hand in one frame; a frame whose payload length falls outside 1..max_payload_bytes gives
// its result at once, otherwise the stored pairs are scanned one slot per clock through a
// single read port and a single pair comparator. A hit ends the scan at the matching slot; a
// miss scans every used slot first, and an empty table skips the scan. The result appears
// with done for one cycle only, in the first cycle busy is low again; the receiver cannot
// stall and must take it then. The table is tracked by a fill count, so it needs no clearing
// pass after reset. Configuration writes must go in while the block is idle; the block
// itself does not enforce this.
module replay_pair_counter_table
	import rpct_pkg::*;
#(
	parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
	parameter int COUNT_BITS  = COUNT_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  logic [FLEN_W-1:0]    frame_length,
	input  logic [RLEN_W-1:0]    radiotap_length,
	input  logic [MAC_W-1:0]     source_mac,
	input  logic [MAC_W-1:0]     dest_mac,
	input  logic                 cfg_write,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	output logic                 done,
	output logic [1:0]           action,
	output logic [IDX_OUT_W-1:0] entry_index,
	output logic [CNT_OUT_W-1:0] pair_count,
	output logic                 alarm
);

	localparam int IDX_W  = $clog2(TABLE_DEPTH);
	localparam int USED_W = IDX_W + 1;
	localparam logic [USED_W-1:0]     FULL_COUNT = USED_W'(TABLE_DEPTH);
	localparam logic [COUNT_BITS-1:0] ONE_COUNT  = COUNT_BITS'(1);

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_SCAN = 3'b010,
		S_MISS = 3'b100
	} state_t;

	state_t              state_q, state_d;
	logic [MAXPL_W-1:0]  max_payload_q;
	logic [THR_W-1:0]    alarm_thr_q;
	logic [HDR_W-1:0]    header_q;
	logic [MAC_W-1:0]    key_src_q;
	logic [MAC_W-1:0]    key_dst_q;
	logic [USED_W-1:0]   used_q;
	logic [IDX_W-1:0]    rd_idx_q;
	logic                issue_q;
	logic                cmp_v_s1;
	logic                cmp_last_s1;
	logic [IDX_W-1:0]    cmp_idx_s1;
	logic                done_q;
	action_t             action_q;
	logic [IDX_W-1:0]    idx_q;
	logic [COUNT_BITS-1:0] cnt_q;
	logic                alarm_q;

	logic                  accept;
	logic                  len_ok;
	logic                  full;
	logic                  hit_now;
	logic                  miss_last;
	logic                  rd_en;
	logic                  rd_last;
	logic [MAC_W-1:0]      rd_src;
	logic [MAC_W-1:0]      rd_dst;
	logic [COUNT_BITS-1:0] rd_cnt;
	logic                  wr_en;
	logic [IDX_W-1:0]      wr_addr;
	logic [COUNT_BITS-1:0] wr_cnt;
	match_t                match;
	logic [COUNT_BITS-1:0] match_cnt;
	logic                  res_load;
	action_t               res_action;
	logic [IDX_W-1:0]      res_idx;
	logic [COUNT_BITS-1:0] res_cnt;
	logic                  res_alarm;
	logic [IDX_W+IDX_OUT_W-1:0]      idx_wide;
	logic [COUNT_BITS+CNT_OUT_W-1:0] cnt_wide;

	assign busy    = (state_q != S_IDLE);
	assign accept  = start && (state_q == S_IDLE);
	assign len_ok  = payload_ok(frame_length, radiotap_length, header_q, max_payload_q);
	assign full    = (used_q == FULL_COUNT);
	assign rd_en   = (state_q == S_SCAN) && issue_q;
	assign rd_last = (USED_W'({1'b0, rd_idx_q}) + 1'b1) == used_q;

	assign hit_now   = (state_q == S_SCAN) && cmp_v_s1 && match.hit;
	assign miss_last = (state_q == S_SCAN) && cmp_v_s1 && !match.hit && cmp_last_s1;

	assign wr_en   = hit_now || ((state_q == S_MISS) && !full);
	assign wr_addr = hit_now ? cmp_idx_s1 : used_q[IDX_W-1:0];
	assign wr_cnt  = hit_now ? match_cnt : ONE_COUNT;

	rpct_table #(
		.TABLE_DEPTH(TABLE_DEPTH),
		.COUNT_BITS (COUNT_BITS),
		.IDX_W      (IDX_W)
	) u_table (
		.clk    (clk),
		.rd_en  (rd_en),
		.rd_addr(rd_idx_q),
		.rd_src (rd_src),
		.rd_dst (rd_dst),
		.rd_cnt (rd_cnt),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_src (key_src_q),
		.wr_dst (key_dst_q),
		.wr_cnt (wr_cnt)
	);

	rpct_match #(
		.COUNT_BITS(COUNT_BITS)
	) u_match (
		.ent_src  (rd_src),
		.ent_dst  (rd_dst),
		.ent_cnt  (rd_cnt),
		.key_src  (key_src_q),
		.key_dst  (key_dst_q),
		.threshold(alarm_thr_q),
		.res      (match),
		.next_cnt (match_cnt)
	);

	always_comb begin
		state_d    = state_q;
		res_load   = 1'b0;
		res_action = ACT_IGNORED;
		res_idx    = '0;
		res_cnt    = '0;
		res_alarm  = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (!len_ok) begin
						res_load = 1'b1;
					end else if (used_q == '0) begin
						state_d = S_MISS;
					end else begin
						state_d = S_SCAN;
					end
				end
			end
			S_SCAN: begin
				if (hit_now) begin
					state_d    = S_IDLE;
					res_load   = 1'b1;
					res_action = ACT_HIT;
					res_idx    = cmp_idx_s1;
					res_cnt    = match_cnt;
					res_alarm  = match.alarm;
				end else if (miss_last) begin
					state_d = S_MISS;
				end
			end
			S_MISS: begin
				state_d  = S_IDLE;
				res_load = 1'b1;
				if (full) begin
					res_action = ACT_DROPPED;
				end else begin
					res_action = ACT_INSERTED;
					res_idx    = used_q[IDX_W-1:0];
					res_cnt    = ONE_COUNT;
					res_alarm  = (alarm_thr_q <= THR_W'(1));
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			max_payload_q <= MAX_PAYLOAD_RST;
			alarm_thr_q   <= ALARM_THR_RST;
			header_q      <= HEADER_RST;
			used_q        <= '0;
			rd_idx_q      <= '0;
			issue_q       <= 1'b0;
			cmp_v_s1      <= 1'b0;
			cmp_last_s1   <= 1'b0;
			done_q        <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= res_load;

			if (cfg_write) begin
				unique case (cfg_index)
					REG_MAX_PAYLOAD: max_payload_q <= cfg_data[MAXPL_W-1:0];
					REG_ALARM_THR:   alarm_thr_q   <= cfg_data[THR_W-1:0];
					REG_HEADER:      header_q      <= cfg_data[HDR_W-1:0];
					default: ;
				endcase
			end

			if (accept) begin
				rd_idx_q <= '0;
				issue_q  <= 1'b1;
				cmp_v_s1 <= 1'b0;
			end else if (rd_en) begin
				// advance the read pointer; the compare stage handles this slot in the next cycle
				rd_idx_q    <= rd_idx_q + 1'b1;
				cmp_v_s1    <= 1'b1;
				cmp_idx_s1  <= rd_idx_q;
				cmp_last_s1 <= rd_last;
				if (rd_last) begin
					issue_q <= 1'b0;
				end
			end else begin
				cmp_v_s1 <= 1'b0;
			end

			if ((state_q == S_MISS) && !full) begin
				used_q <= used_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			key_src_q <= source_mac;
			key_dst_q <= dest_mac;
		end
		if (res_load) begin
			action_q <= res_action;
			idx_q    <= res_idx;
			cnt_q    <= res_cnt;
			alarm_q  <= res_alarm;
		end
	end

	assign idx_wide = {{IDX_OUT_W{1'b0}}, idx_q};
	assign cnt_wide = {{CNT_OUT_W{1'b0}}, cnt_q};

	assign done        = done_q;
	assign action      = action_q;
	assign entry_index = idx_wide[IDX_OUT_W-1:0];
	assign pair_count  = cnt_wide[CNT_OUT_W-1:0];
	assign alarm       = alarm_q;

endmodule

[sv/rpct_checker.sv]
`include "replay_pair_counter_table_macros.svh"

module rpct_checker
	import rpct_pkg::*;
(
	input logic                 clk,
	input logic                 arst_n,
	input logic                 start,
	input logic                 busy,
	input logic                 done,
	input logic [1:0]           action,
	input logic [IDX_OUT_W-1:0] entry_index,
	input logic [CNT_OUT_W-1:0] pair_count,
	input logic                 alarm
);

	logic empty_act;
	logic no_data;

	assign empty_act = (action == ACT_IGNORED) || (action == ACT_DROPPED);
	assign no_data   = (entry_index == '0) && (pair_count == '0) && !alarm;

	// an accepted item either finishes at once or holds the block busy
	`RPCT_ASSERT(a_accept_busy, start && !busy |=> busy || done, "accepted item lost")
	`RPCT_ASSERT(a_fall_done, $fell(busy) |-> done, "busy dropped without a result")
	`RPCT_NEVER(a_done_busy, done && busy, "result strobe while busy")
	`RPCT_ASSERT(a_empty_result, done && empty_act |-> no_data, "empty result carries data")
	`RPCT_ASSERT(a_insert_one, done && action == ACT_INSERTED |-> pair_count == 16'd1, "insert count not one")

endmodule

bind replay_pair_counter_table rpct_checker u_rpct_checker (.*);
